>>> hw/rtl/mst_pkg.sv
// Package: constants, types and colour table for the multi-screen text terminal.
package mst_pkg;

  localparam int SCREENS = 6;
  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = ROWS * COLUMNS;
  localparam int SCR_W = 3;
  localparam int IDX_W = 11;
  localparam int CHAR_W = 9;
  localparam int DATA_W = 16;
  localparam int SEQ_W = 8;
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ADDR_W = SCR_W + IDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int SCROLL_LIMIT = (ROWS - 1) * COLUMNS;
  localparam int MOVE_CELLS = (ROWS - 2) * COLUMNS;

  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 9'd10;
  localparam logic [CHAR_W-1:0] CODE_ESC = 9'd27;
  localparam logic [CHAR_W-1:0] CODE_SEMI = 9'd59;
  localparam logic [CHAR_W-1:0] CODE_ZERO = 9'd48;
  localparam logic [CHAR_W-1:0] CODE_NINE = 9'd57;
  localparam logic [CHAR_W-1:0] CODE_LBRACKET = 9'd91;
  localparam logic [CHAR_W-1:0] CODE_M = 9'd109;
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 9'd256;
  localparam logic [CHAR_W-1:0] SWITCH_FIRST = 9'd151;
  localparam logic [CHAR_W-1:0] SWITCH_LAST = 9'd156;

  localparam logic [DATA_W-1:0] ATTR_DEFAULT = 16'h0700;
  localparam logic [DATA_W-1:0] BLANK_CHAR = 16'h0020;
  localparam logic [DATA_W-1:0] FG_KEEP = 16'hf0ff;
  localparam logic [DATA_W-1:0] BG_KEEP = 16'h0fff;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_RDWAIT, ST_SCROLL, ST_ZERO, ST_BLANK, ST_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  function automatic logic [DATA_W-1:0] colour_lut(input logic [4:0] i);
    logic [DATA_W-1:0] r;
    case (i)
      5'd1:    r = 16'h0400;
      5'd2:    r = 16'h0200;
      5'd3:    r = 16'h0e00;
      5'd4:    r = 16'h0100;
      5'd5:    r = 16'h0500;
      5'd6:    r = 16'h0300;
      5'd7:    r = 16'h0f00;
      5'd9:    r = 16'h0f00;
      5'd11:   r = 16'h4000;
      5'd12:   r = 16'h2000;
      5'd13:   r = 16'h6000;
      5'd14:   r = 16'h1000;
      5'd15:   r = 16'h5000;
      5'd16:   r = 16'h3000;
      5'd17:   r = 16'h0f00;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/mst_cell_ram.sv
// Cell store: one write port and one registered read port.
module mst_cell_ram (
  input  logic                          clk,
  input  mst_pkg::ram_req_t             req,
  output logic [mst_pkg::DATA_W-1:0]    rd_data
);
  import mst_pkg::*;

  logic [DATA_W-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

>>> hw/rtl/multi_screen_text_terminal.sv
// Top level: six-screen text terminal with per-screen cursor and colour parser.
//
//  channel | dir | fields                                   | handshake
//  in_     | in  | command, screen, char_code, cell_index   | in_valid / in_stall
//  out_    | out | cell_data, cursor, shown_screen          | out_valid / out_stall
//
// After reset the whole cell store is swept to zero, with in_stall high.
// A request passes ST_EXEC, then ST_RDWAIT (read) or ST_BLANK (valid put or switch), then ST_DONE.
// A put that pushes the cursor into the last row scrolls: ST_SCROLL moves the cells up a row
// through the memory's read and write ports, and ST_ZERO clears the row.
// One request is in work at a time; the next is taken once the result is registered.
module multi_screen_text_terminal (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [mst_pkg::SCR_W-1:0]     in_screen,
  input  logic [mst_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [mst_pkg::IDX_W-1:0]     in_cell_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mst_pkg::DATA_W-1:0]    out_cell_data,
  output logic [mst_pkg::IDX_W-1:0]     out_cursor,
  output logic [mst_pkg::SCR_W-1:0]     out_shown_screen
);
  import mst_pkg::*;

  state_t st_r, st_nxt;

  logic              cmd_r;
  logic [SCR_W-1:0]  scr_r;
  logic [CHAR_W-1:0] chr_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  cnt_r;
  logic [ADDR_W-1:0] clr_r;
  logic [SCR_W-1:0]  tgt_r;
  logic [SCR_W-1:0]  vis_r;
  logic [DATA_W-1:0] dat_r;

  logic [IDX_W-1:0]  cur_r  [SCREENS];
  logic [COL_W-1:0]  col_r  [SCREENS];
  logic [DATA_W-1:0] attr_r [SCREENS];
  logic              esc_r  [SCREENS];
  logic              inseq_r[SCREENS];
  logic [SEQ_W-1:0]  seqv_r [SCREENS];

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic [IDX_W-1:0]  out_cur_r;
  logic [SCR_W-1:0]  out_scr_r;

  ram_req_t          req;
  logic [DATA_W-1:0] rd_data;

  mst_cell_ram u_ram (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  logic             scr_ok, rd_ok, is_switch, sw_ok, out_free;
  logic [SCR_W-1:0] sidx, sw_n;

  assign scr_ok    = {1'b0, scr_r} < (SCR_W+1)'(SCREENS);
  assign sidx      = scr_ok ? scr_r : '0;
  assign rd_ok     = scr_ok && (idx_r < IDX_W'(CELLS));
  assign is_switch = (cmd_r == CMD_PUT) && (chr_r >= SWITCH_FIRST) && (chr_r <= SWITCH_LAST);
  assign sw_n      = SCR_W'(chr_r - SWITCH_FIRST);
  assign sw_ok     = {1'b0, sw_n} < (SCR_W+1)'(SCREENS);
  assign out_free  = !out_valid_r || !out_stall;

  // put path
  logic [IDX_W-1:0]  p, p_n, p_fin;
  logic [COL_W-1:0]  col, col_n;
  logic [DATA_W-1:0] attr, attr_n;
  logic [SEQ_W-1:0]  seqv, seqv_n;
  logic              esc_n, inseq_n, wr_char, scroll;
  logic [11:0]       prod;
  logic [4:0]        lut_i;

  always_comb begin
    p       = cur_r[sidx];
    col     = col_r[sidx];
    attr    = attr_r[sidx];
    seqv    = seqv_r[sidx];
    p_n     = p;
    col_n   = col;
    attr_n  = attr;
    seqv_n  = seqv;
    esc_n   = 1'b0;
    inseq_n = inseq_r[sidx];
    wr_char = 1'b0;
    prod    = 12'({4'b0, seqv} * 12'd10 + 12'(chr_r - CODE_ZERO));
    lut_i   = 5'(seqv - SEQ_W'(30));
    if (chr_r == CODE_ESC) begin
      esc_n = 1'b1;
    end else if (chr_r == CODE_NEWLINE) begin
      p_n   = p + IDX_W'(COLUMNS) - IDX_W'(col);
      col_n = '0;
    end else if (chr_r == CODE_BACKSPACE) begin
      if (p != '0) begin
        p_n   = p - 1'b1;
        col_n = (col == '0) ? COL_W'(COLUMNS - 1) : col - 1'b1;
      end
    end else if (esc_r[sidx] && chr_r == CODE_LBRACKET) begin
      inseq_n = 1'b1;
    end else if (inseq_r[sidx]) begin
      if (chr_r >= CODE_ZERO && chr_r <= CODE_NINE) begin
        seqv_n = (prod > 12'd255) ? 8'd255 : prod[SEQ_W-1:0];
      end
      if (chr_r == CODE_M || chr_r == CODE_SEMI) begin
        if (seqv == '0) begin
          attr_n = ATTR_DEFAULT;
        end else if (seqv >= 8'd30 && seqv <= 8'd39) begin
          attr_n = (attr & FG_KEEP) | colour_lut(lut_i);
        end else if (seqv >= 8'd40 && seqv <= 8'd49) begin
          attr_n = (attr & BG_KEEP) | colour_lut(lut_i);
        end
        seqv_n = '0;
        if (chr_r == CODE_M) begin
          inseq_n = 1'b0;
        end
      end
    end else begin
      wr_char = 1'b1;
      p_n     = p + 1'b1;
      col_n   = (col == COL_W'(COLUMNS - 1)) ? '0 : col + 1'b1;
    end
    scroll = p_n >= IDX_W'(SCROLL_LIMIT);
    p_fin  = scroll ? p_n - IDX_W'(COLUMNS) : p_n;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR:  if (clr_r == ADDR_W'(MEM_DEPTH - 1)) st_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) st_nxt = ST_EXEC;
      ST_EXEC: begin
        if (cmd_r == CMD_READ) st_nxt = ST_RDWAIT;
        else if (is_switch) st_nxt = sw_ok ? ST_BLANK : ST_DONE;
        else if (!scr_ok) st_nxt = ST_DONE;
        else if (scroll) st_nxt = ST_SCROLL;
        else st_nxt = ST_BLANK;
      end
      ST_RDWAIT: st_nxt = ST_DONE;
      ST_SCROLL: if (cnt_r == IDX_W'(MOVE_CELLS)) st_nxt = ST_ZERO;
      ST_ZERO:   if (cnt_r == IDX_W'(SCROLL_LIMIT - 1)) st_nxt = ST_BLANK;
      ST_BLANK:  st_nxt = ST_DONE;
      ST_DONE:   if (out_free) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // memory port
  always_comb begin
    req.we    = 1'b0;
    req.waddr = {scr_r, cnt_r};
    req.wdata = '0;
    req.raddr = {scr_r, IDX_W'(cnt_r + IDX_W'(COLUMNS))};
    unique case (st_r)
      ST_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = clr_r;
      end
      ST_EXEC: begin
        req.raddr = {scr_r, idx_r};
        req.we    = (cmd_r == CMD_PUT) && !is_switch && scr_ok && wr_char;
        req.waddr = {scr_r, p};
        req.wdata = attr | {8'h00, chr_r[7:0]};
      end
      ST_SCROLL: begin
        req.we    = cnt_r != '0;
        req.waddr = {scr_r, IDX_W'(cnt_r - 1'b1)};
        req.wdata = rd_data;
      end
      ST_ZERO:  req.we = 1'b1;
      ST_BLANK: begin
        req.we    = 1'b1;
        req.waddr = {tgt_r, cur_r[tgt_r]};
        req.wdata = attr_r[tgt_r] | BLANK_CHAR;
      end
      default: req.we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_r       <= '0;
      vis_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SCREENS; i++) begin
        cur_r[i]   <= '0;
        col_r[i]   <= '0;
        attr_r[i]  <= ATTR_DEFAULT;
        esc_r[i]   <= 1'b0;
        inseq_r[i] <= 1'b0;
        seqv_r[i]  <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      unique case (st_r)
        ST_CLEAR: clr_r <= clr_r + 1'b1;
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_command;
            scr_r <= in_screen;
            chr_r <= in_char_code;
            idx_r <= in_cell_index;
          end
        end
        ST_EXEC: begin
          dat_r <= '0;
          tgt_r <= scr_r;
          cnt_r <= '0;
          if (cmd_r == CMD_PUT && is_switch) begin
            tgt_r <= sw_n;
            if (sw_ok) vis_r <= sw_n;
          end else if (cmd_r == CMD_PUT && scr_ok) begin
            cur_r[sidx]   <= p_fin;
            col_r[sidx]   <= col_n;
            attr_r[sidx]  <= attr_n;
            esc_r[sidx]   <= esc_n;
            inseq_r[sidx] <= inseq_n;
            seqv_r[sidx]  <= seqv_n;
          end
        end
        ST_RDWAIT: dat_r <= rd_ok ? rd_data : '0;
        ST_SCROLL: if (cnt_r != IDX_W'(MOVE_CELLS)) cnt_r <= cnt_r + 1'b1;
        ST_ZERO:   cnt_r <= cnt_r + 1'b1;
        ST_DONE: begin
          if (out_free) begin
            out_data_r  <= dat_r;
            out_cur_r   <= scr_ok ? cur_r[sidx] : '0;
            out_scr_r   <= vis_r;
          end
        end
        default: clr_r <= clr_r;
      endcase
    end
  end

  assign in_stall         = st_r != ST_IDLE;
  assign out_valid        = out_valid_r;
  assign out_cell_data    = out_data_r;
  assign out_cursor       = out_cur_r;
  assign out_shown_screen = out_scr_r;

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE && out_valid_r && out_stall) |=> st_r == ST_DONE)
    else $error("result dropped while output stalled");

  a_no_write_rd: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_RDWAIT |-> !req.we)
    else $error("write during read wait");

  a_scroll_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_SCROLL |-> cnt_r <= IDX_W'(MOVE_CELLS))
    else $error("scroll counter overrun");

  a_blank_row: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_BLANK |-> cur_r[tgt_r] < IDX_W'(SCROLL_LIMIT))
    else $error("cursor in last row");

endmodule

>>> tb/tb_top.sv
// Testbench for the multi-screen text terminal: predicts cells, cursors and visible screen.
module tb_top;
  import mst_pkg::*;

  typedef struct {
    logic [DATA_W-1:0] cell_data;
    logic [IDX_W-1:0]  cursor;
    logic [SCR_W-1:0]  shown;
  } reply_t;

  class terminal_scoreboard;
    logic [DATA_W-1:0] cells[SCREENS][CELLS];
    int                cur[SCREENS];
    logic [DATA_W-1:0] attr[SCREENS];
    bit                esc[SCREENS];
    bit                in_seq[SCREENS];
    int                seq_val[SCREENS];
    int                vis;
    logic [DATA_W-1:0] colours[20];
    reply_t            expected_replies[$];
    int                mismatches;

    function new();
      colours = '{16'h0000, 16'h0400, 16'h0200, 16'h0e00, 16'h0100, 16'h0500, 16'h0300,
                  16'h0f00, 16'h0000, 16'h0f00, 16'h0000, 16'h4000, 16'h2000, 16'h6000,
                  16'h1000, 16'h5000, 16'h3000, 16'h0f00, 16'h0000, 16'h0000};
      foreach (cells[s, i]) cells[s][i] = '0;
      for (int s = 0; s < SCREENS; s++) begin
        cur[s] = 0;
        attr[s] = ATTR_DEFAULT;
        esc[s] = 0;
        in_seq[s] = 0;
        seq_val[s] = 0;
      end
      vis = 0;
      mismatches = 0;
    endfunction

    function void blank(int s);
      if (cur[s] < CELLS) cells[s][cur[s]] = BLANK_CHAR | attr[s];
    endfunction

    function void apply_colour(int s);
      int v;
      v = seq_val[s];
      if (v == 0) attr[s] = ATTR_DEFAULT;
      else if (v >= 30 && v <= 39) attr[s] = (attr[s] & FG_KEEP) | colours[v - 30];
      else if (v >= 40 && v <= 49) attr[s] = (attr[s] & BG_KEEP) | colours[v - 30];
    endfunction

    function void put_char(int s, logic [CHAR_W-1:0] c);
      int p;
      int v;
      p = cur[s];
      if (c == CODE_ESC) begin
        esc[s] = 1;
      end else begin
        if (c == CODE_NEWLINE) begin
          p += COLUMNS - p % COLUMNS;
        end else if (c == CODE_BACKSPACE) begin
          if (p > 0) p--;
        end else if (esc[s] && c == CODE_LBRACKET) begin
          in_seq[s] = 1;
        end else if (in_seq[s]) begin
          if (c >= CODE_ZERO && c <= CODE_NINE) begin
            v = seq_val[s] * 10 + int'(c - CODE_ZERO);
            seq_val[s] = v > 255 ? 255 : v;
          end
          if (c == CODE_M || c == CODE_SEMI) begin
            apply_colour(s);
            seq_val[s] = 0;
            if (c == CODE_M) in_seq[s] = 0;
          end
        end else begin
          if (p < CELLS) cells[s][p] = {8'h00, c[7:0]} | attr[s];
          p++;
        end
        esc[s] = 0;
      end
      if (p / COLUMNS >= ROWS - 1) begin
        for (int i = 0; i < MOVE_CELLS; i++) cells[s][i] = cells[s][i + COLUMNS];
        p -= COLUMNS;
        for (int i = p; i < SCROLL_LIMIT; i++) cells[s][i] = '0;
      end
      cur[s] = p;
      blank(s);
    endfunction

    function void note_request(logic cmd, logic [SCR_W-1:0] scr, logic [CHAR_W-1:0] c,
                               logic [IDX_W-1:0] idx);
      reply_t r;
      bit ok;
      int n;
      ok = scr < SCREENS;
      r.cell_data = '0;
      if (cmd == CMD_READ) begin
        if (ok && idx < CELLS) r.cell_data = cells[scr][idx];
      end else if (c >= SWITCH_FIRST && c <= SWITCH_LAST) begin
        n = int'(c - SWITCH_FIRST);
        if (n < SCREENS) begin
          vis = n;
          blank(n);
        end
      end else if (ok) begin
        put_char(scr, c);
      end
      r.cursor = ok ? IDX_W'(cur[scr]) : '0;
      r.shown = SCR_W'(vis);
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic [DATA_W-1:0] d, logic [IDX_W-1:0] cu,
                              logic [SCR_W-1:0] sh);
      reply_t e;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply data=%h cursor=%0d shown=%0d", $time, d, cu, sh);
        mismatches++;
        return;
      end
      e = expected_replies.pop_front();
      if (d !== e.cell_data) begin
        $display("%0t: cell_data expected %h actual %h", $time, e.cell_data, d);
        mismatches++;
      end
      if (cu !== e.cursor) begin
        $display("%0t: cursor expected %0d actual %0d", $time, e.cursor, cu);
        mismatches++;
      end
      if (sh !== e.shown) begin
        $display("%0t: shown_screen expected %0d actual %0d", $time, e.shown, sh);
        mismatches++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int ITEM_COUNT = 1900;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic               in_command = 0;
  logic [SCR_W-1:0]   in_screen = '0;
  logic [CHAR_W-1:0]  in_char_code = '0;
  logic [IDX_W-1:0]   in_cell_index = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [DATA_W-1:0]  out_cell_data;
  logic [IDX_W-1:0]   out_cursor;
  logic [SCR_W-1:0]   out_shown_screen;

  terminal_scoreboard sb = new();
  int send_idle = 23;
  int recv_idle = 65;
  bit hold_off = 0;
  int accepted = 0;
  int sent = 0;
  int quiet_cycles = 0;

  multi_screen_text_terminal dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_request(in_command, in_screen, in_char_code, in_cell_index);
      accepted++;
    end
    if (rst_n && out_valid && !out_stall)
      sb.check_reply(out_cell_data, out_cursor, out_shown_screen);
  end

  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    wait (accepted >= 150);
    @(posedge clk);
    hold_off = 1;
    repeat (400) @(posedge clk);
    hold_off = 0;
  end

  task automatic send(logic cmd, logic [SCR_W-1:0] scr, logic [CHAR_W-1:0] c,
                      logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_command <= cmd;
    in_screen <= scr;
    in_char_code <= c;
    in_cell_index <= idx;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic put(logic [SCR_W-1:0] scr, logic [CHAR_W-1:0] c);
    send(CMD_PUT, scr, c, IDX_W'($urandom_range(2047)));
  endtask

  task automatic put_number(logic [SCR_W-1:0] scr, int v);
    string t;
    t = $sformatf("%0d", v);
    for (int i = 0; i < t.len(); i++) put(scr, CHAR_W'(t[i]));
  endtask

  task automatic colour_burst(logic [SCR_W-1:0] scr);
    int vals;
    int v;
    put(scr, CODE_ESC);
    if ($urandom_range(9) != 0) put(scr, CODE_LBRACKET);
    vals = $urandom_range(1, 3);
    for (int k = 0; k < vals; k++) begin
      case ($urandom_range(3))
        0: v = 0;
        1: v = $urandom_range(30, 39);
        2: v = $urandom_range(40, 49);
        default: v = $urandom_range(999);
      endcase
      put_number(scr, v);
      if ($urandom_range(7) == 0) put(scr, CHAR_W'($urandom_range(32, 126)));
      put(scr, (k == vals - 1) ? CODE_M : CODE_SEMI);
    end
  endtask

  task automatic random_request();
    logic [SCR_W-1:0] scr;
    int pick;
    scr = ($urandom_range(19) == 0) ? SCR_W'($urandom_range(6, 7))
                                    : SCR_W'($urandom_range(SCREENS - 1));
    pick = $urandom_range(99);
    if (pick < 20)
      send(CMD_READ, scr, CHAR_W'($urandom_range(511)),
           ($urandom_range(9) == 0) ? IDX_W'($urandom_range(2047))
                                    : IDX_W'($urandom_range(CELLS - 1)));
    else if (pick < 60) put(scr, CHAR_W'($urandom_range(32, 126)));
    else if (pick < 70) put(scr, CODE_NEWLINE);
    else if (pick < 75) put(scr, CODE_BACKSPACE);
    else if (pick < 79) put(scr, CHAR_W'($urandom_range(SWITCH_FIRST, SWITCH_LAST)));
    else if (pick < 86) put(scr, CHAR_W'($urandom_range(511)));
    else colour_burst(scr);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed
    send(CMD_READ, 3'd0, '0, 11'd0);
    put(3'd0, CODE_BACKSPACE);
    put(3'd0, 9'd65);
    put(3'd0, 9'd0);
    put(3'd0, 9'd511);
    put(3'd0, 9'd257);
    put(3'd0, CODE_ESC);
    put(3'd0, CODE_LBRACKET);
    put_number(3'd0, 31);
    put(3'd0, CODE_SEMI);
    put_number(3'd0, 44);
    put(3'd0, CODE_SEMI);
    put_number(3'd0, 99999);
    put(3'd0, CODE_M);
    put(3'd0, 9'd66);
    put(3'd1, SWITCH_LAST);
    put(3'd7, SWITCH_FIRST);
    put(3'd6, 9'd67);
    send(CMD_READ, 3'd7, '0, 11'd5);
    send(CMD_READ, 3'd0, '0, 11'd2047);
    send(CMD_READ, 3'd0, '0, 11'd2000);
    send(CMD_READ, 3'd0, '0, 11'd1);
    for (int i = 0; i < ROWS; i++) put(3'd2, CODE_NEWLINE);
    send(CMD_READ, 3'd2, '0, 11'(SCROLL_LIMIT - COLUMNS));

    while (sent < ITEM_COUNT) begin
      if (sent >= 1300) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (sent >= 650) begin
        send_idle = 65;
        recv_idle = 23;
      end
      random_request();
    end
    in_valid <= 0;

    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_replies.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

>>> sim.f
hw/rtl/mst_pkg.sv
hw/rtl/mst_cell_ram.sv
hw/rtl/multi_screen_text_terminal.sv
tb/tb_top.sv
